// ===== rtl/core/alb_pkg.sv =====
// Package for the ambient light backlight ramp: fixed widths, register
// indexes, command codes and the structs passed between the core modules.
// No dependencies.
`default_nettype none

package alb_pkg;

    localparam int THR_BITS    = 16;
    localparam int MAX_POINTS  = 4;
    localparam int ZONE_W      = 3;
    localparam int LEVEL_W     = 3;
    localparam int BRIGHT_W    = 6;
    localparam int ROW_BITS    = 30;
    localparam int TABLE_W     = 60;
    localparam int NUM_WORDS   = 4;
    localparam int MASK_W      = 8;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int REG_IDX_W   = 3;

    // Register indexes, taken from paddr[5:3].
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLDS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_01   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_23   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_45   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_67   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_VALID_MASK = 3'd6;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_LEVEL = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0]                   thresholds;
        logic [2:0]                          active_points;
        logic [NUM_WORDS-1:0][TABLE_W-1:0]   levels;
        logic [MASK_W-1:0]                   valid_mask;
    } t_cfg;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [BRIGHT_W-1:0] target;
        logic [ZONE_W-1:0]   zone;
        logic                changed;
        logic                row_valid;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/alb_if.sv =====
// Valid/ready channel interfaces for the ambient light backlight ramp:
// the sample channel and the result channel. No dependencies.
`default_nettype none

interface alb_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;
    logic [2:0]             new_menu_level;

    modport source (output valid, command, sample, new_menu_level, input ready);
    modport sink   (input valid, command, sample, new_menu_level, output ready);
endinterface

interface alb_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] brightness;
    logic [5:0] target;
    logic [2:0] zone;
    logic       changed;
    logic       row_valid;

    modport source (output valid, brightness, target, zone, changed, row_valid,
                    input ready);
    modport sink   (input valid, brightness, target, zone, changed, row_valid,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ambient_light_backlight_ramp.sv =====
// Top level of the ambient light backlight ramp: input register, zone
// classifier, ramp stage and result register. Depends on alb_pkg, alb_if,
// alb_regs, alb_zone and alb_ramp.
//
// Usage:
//   Sample transactions arrive on i_in (command, sample, new_menu_level) and
//   each one produces exactly one result transaction on o_out (brightness,
//   target, zone, changed, row_valid), in order.
//   The configuration registers sit on the APB-style port at byte address
//   8*i; write them only while no transaction is in flight.
//
// Flow and throughput:
//   A transaction accepted at a clock edge is held in the input register,
//   classified combinationally, and applied to the brightness state at the
//   edge that moves it into the result register, from which its result is
//   presented on o_out. One transaction is taken every cycle while the
//   receiver keeps o_out.ready high; the single brightness/menu-level update
//   in the ramp stage sets that figure.
//
// Reset (i_rst_n low at a clock edge) empties both registers, sets the
// brightness to 0, the menu level to 5 and the registers to their defaults.
// When the receiver holds o_out.ready low, the result register keeps its
// transaction, the stage behind it stalls, and i_in.ready falls once the
// input register is also full; nothing is dropped or repeated.
`default_nettype none

module ambient_light_backlight_ramp
    import alb_pkg::*;
#(
    parameter int NUM_POINTS  = 4,
    parameter int MENU_LEVELS = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    alb_in_if.sink                 i_in,
    alb_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg                   w_cfg;

    // Input register.
    logic                   r_in_valid;
    logic                   r_command;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [LEVEL_W-1:0]     r_new_level;

    // Result register.
    logic                   r_out_valid;
    t_result                r_out;

    logic                   w_fire;
    logic                   w_in_ready;
    logic [ZONE_W-1:0]      w_zone;
    t_result                w_result;

    alb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held item moves into the result register whenever that register
    // is empty or is being drained in the same cycle.
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_fire;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_command   <= i_in.command;
            r_sample    <= i_in.sample;
            r_new_level <= i_in.new_menu_level;
        end
    end

    alb_zone #(
        .NUM_POINTS  (NUM_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_zone (
        .i_sample        (r_sample),
        .i_thresholds    (w_cfg.thresholds),
        .i_active_points (w_cfg.active_points),
        .o_zone          (w_zone)
    );

    alb_ramp #(
        .MENU_LEVELS (MENU_LEVELS)
    ) u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_command   (r_command),
        .i_new_level (r_new_level),
        .i_zone      (w_zone),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.brightness = r_out.brightness;
    assign o_out.target     = r_out.target;
    assign o_out.zone       = r_out.zone;
    assign o_out.changed    = r_out.changed;
    assign o_out.row_valid  = r_out.row_valid;

endmodule

`default_nettype wire

// ===== rtl/core/alb_regs.sv =====
// APB-style configuration register file for the backlight ramp.
// Depends on alb_pkg.
`default_nettype none

module alb_regs
    import alb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresholds    <= '1;
            r_cfg.active_points <= 3'(MAX_POINTS);
            r_cfg.levels        <= '0;
            r_cfg.valid_mask    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_THRESHOLDS: r_cfg.thresholds    <= pwdata;
                REG_ACTIVE:     r_cfg.active_points <= pwdata[2:0];
                REG_TABLE_01:   r_cfg.levels[0]     <= pwdata[TABLE_W-1:0];
                REG_TABLE_23:   r_cfg.levels[1]     <= pwdata[TABLE_W-1:0];
                REG_TABLE_45:   r_cfg.levels[2]     <= pwdata[TABLE_W-1:0];
                REG_TABLE_67:   r_cfg.levels[3]     <= pwdata[TABLE_W-1:0];
                REG_VALID_MASK: r_cfg.valid_mask    <= pwdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLDS: prdata = r_cfg.thresholds;
            REG_ACTIVE:     prdata = DATA_W'(r_cfg.active_points);
            REG_TABLE_01:   prdata = DATA_W'(r_cfg.levels[0]);
            REG_TABLE_23:   prdata = DATA_W'(r_cfg.levels[1]);
            REG_TABLE_45:   prdata = DATA_W'(r_cfg.levels[2]);
            REG_TABLE_67:   prdata = DATA_W'(r_cfg.levels[3]);
            REG_VALID_MASK: prdata = DATA_W'(r_cfg.valid_mask);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/alb_zone.sv =====
// Illuminance zone classifier: parallel compare of one sample against the
// active thresholds. Depends on alb_pkg.
`default_nettype none

module alb_zone
    import alb_pkg::*;
#(
    parameter int NUM_POINTS  = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [DATA_W-1:0]      i_thresholds,
    input  wire logic [2:0]             i_active_points,
    output logic      [ZONE_W-1:0]      o_zone
);

    logic [2:0]          w_count;
    logic [THR_BITS-1:0] w_sample;

    assign w_sample = THR_BITS'(i_sample);
    assign w_count  = (i_active_points > 3'(NUM_POINTS)) ? 3'(NUM_POINTS)
                                                          : i_active_points;

    // The lowest-indexed active threshold above the sample wins; walk from the top
    // down so the lowest index is written last.
    always_comb begin
        o_zone = ZONE_W'(w_count);
        for (int i = NUM_POINTS - 1; i >= 0; i--) begin
            if ((3'(i) < w_count) &&
                (w_sample < i_thresholds[THR_BITS*i +: THR_BITS])) begin
                o_zone = ZONE_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/alb_ramp.sv =====
// Brightness state, menu level, target lookup and ramp step for the
// backlight ramp. Depends on alb_pkg.
`default_nettype none

module alb_ramp
    import alb_pkg::*;
#(
    parameter int MENU_LEVELS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic               i_command,
    input  wire logic [LEVEL_W-1:0] i_new_level,
    input  wire logic [ZONE_W-1:0]  i_zone,
    input  t_cfg                    i_cfg,
    output t_result                 o_result
);

    logic [BRIGHT_W-1:0] r_brightness;
    logic [BRIGHT_W-1:0] n_brightness;
    logic [LEVEL_W-1:0]  r_menu_level;
    logic [LEVEL_W-1:0]  n_menu_level;
    logic                w_valid;
    logic [TABLE_W-1:0]  w_word;
    logic [ROW_BITS-1:0] w_row;
    logic [BRIGHT_W-1:0] w_target;
    logic                w_changed;

    // A level change takes effect for the item that carries it.
    assign n_menu_level = (i_command == CMD_LEVEL) ? i_new_level : r_menu_level;

    assign w_valid = ({1'b0, n_menu_level} < 4'(MENU_LEVELS)) &&
                     i_cfg.valid_mask[n_menu_level];

    assign w_word = i_cfg.levels[n_menu_level[LEVEL_W-1:1]];
    assign w_row  = n_menu_level[0] ? w_word[TABLE_W-1:ROW_BITS]
                                    : w_word[ROW_BITS-1:0];

    always_comb begin
        w_target = '0;
        if (w_valid) begin
            case (i_zone)
                3'd0:    w_target = w_row[ 5: 0];
                3'd1:    w_target = w_row[11: 6];
                3'd2:    w_target = w_row[17:12];
                3'd3:    w_target = w_row[23:18];
                3'd4:    w_target = w_row[29:24];
                default: w_target = '0;
            endcase
        end
    end

    assign w_changed = w_valid && (w_target != r_brightness);

    always_comb begin
        n_brightness = r_brightness;
        if (w_changed) begin
            if (i_command == CMD_LEVEL) begin
                n_brightness = w_target;
            end else if (w_target < r_brightness) begin
                n_brightness = r_brightness - 6'd1;
            end else begin
                n_brightness = r_brightness + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= '0;
            r_menu_level <= LEVEL_RESET;
        end else if (i_fire) begin
            r_brightness <= n_brightness;
            r_menu_level <= n_menu_level;
        end
    end

    assign o_result.brightness = n_brightness;
    assign o_result.target     = w_target;
    assign o_result.zone       = i_zone;
    assign o_result.changed    = w_changed;
    assign o_result.row_valid  = w_valid;

`ifndef SYNTHESIS
    a_tick_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_command == CMD_TICK)) |=>
            (r_brightness == $past(r_brightness) ||
             r_brightness == $past(r_brightness) + 6'd1 ||
             r_brightness == $past(r_brightness) - 6'd1))
        else $error("brightness moved more than one step on a tick");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_brightness) && $stable(r_menu_level)))
        else $error("state changed without a transaction");

    a_level_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_command == CMD_LEVEL)) |=> (r_menu_level == $past(i_new_level)))
        else $error("menu level not stored on a level change");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_ambient_light_backlight_ramp.sv =====
// Testbench for ambient_light_backlight_ramp: directed and random sample transactions,
// checked against a cycle-independent prediction of zone, target and brightness.
// Depends on alb_pkg, alb_if and the RTL of the block.

module tb_ambient_light_backlight_ramp;
    timeunit 1ns;
    timeprecision 1ps;

    import alb_pkg::*;

    localparam int NUM_POINTS      = 4;
    localparam int MENU_LEVELS     = 8;
    localparam int SAMPLE_BITS     = 12;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int MAX_GAP         = 18;
    localparam int LONG_HOLD       = 90;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SHOWN_ERRORS    = 10;
    // The slowest correct run is near 2000 transactions, each with its longest gap
    // and stall, plus the long holds and the register writes; this is several times that.
    localparam int RUN_LIMIT_NS    = 10_000_000;

    // The scoreboard keeps its own copy of the registers and of the brightness
    // and menu level state. Each accepted sample transaction is turned into the
    // result it must cause, and results are compared in order.
    class backlight_scoreboard;
        logic [DATA_W-1:0]   thresholds;
        logic [2:0]          active_points;
        logic [TABLE_W-1:0]  level_rows [NUM_WORDS];
        logic [MASK_W-1:0]   valid_mask;
        logic [BRIGHT_W-1:0] brightness;
        logic [LEVEL_W-1:0]  menu_level;
        t_result             due_reports [$];
        int                  wrong_count;

        function new();
            thresholds    = '1;
            active_points = 3'd4;
            foreach (level_rows[i]) level_rows[i] = '0;
            valid_mask    = '0;
            brightness    = '0;
            menu_level    = LEVEL_RESET;
            wrong_count   = 0;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_THRESHOLDS: thresholds    = value;
                REG_ACTIVE:     active_points = value[2:0];
                REG_TABLE_01:   level_rows[0] = value[TABLE_W-1:0];
                REG_TABLE_23:   level_rows[1] = value[TABLE_W-1:0];
                REG_TABLE_45:   level_rows[2] = value[TABLE_W-1:0];
                REG_TABLE_67:   level_rows[3] = value[TABLE_W-1:0];
                REG_VALID_MASK: valid_mask    = value[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic command, logic [SAMPLE_BITS-1:0] sample,
                                  logic [LEVEL_W-1:0] new_level);
            t_result report;
            int      in_use;
            report = '0;
            if (command == CMD_LEVEL) menu_level = new_level;

            // Walk the active thresholds from the top down so that the lowest-indexed
            // one the sample lies below is the one that sticks.
            in_use = (active_points > NUM_POINTS) ? NUM_POINTS : int'(active_points);
            report.zone = ZONE_W'(in_use);
            for (int i = in_use - 1; i >= 0; i--) begin
                if (sample < thresholds[THR_BITS*i +: THR_BITS]) report.zone = ZONE_W'(i);
            end

            report.row_valid = (menu_level < MENU_LEVELS) && valid_mask[menu_level];
            if (report.row_valid) begin
                report.target = level_rows[menu_level >> 1]
                    [ROW_BITS*menu_level[0] + BRIGHT_W*report.zone +: BRIGHT_W];
                if (report.target != brightness) begin
                    if (command == CMD_LEVEL) brightness = report.target;
                    else if (report.target < brightness) brightness = brightness - 1'b1;
                    else brightness = brightness + 1'b1;
                    report.changed = 1'b1;
                end
            end
            report.brightness = brightness;
            due_reports.push_back(report);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_reports.size() == 0) begin
                wrong_count++;
                if (wrong_count <= SHOWN_ERRORS)
                    $display("unexpected result transaction: brightness %0d target %0d zone %0d",
                             got.brightness, got.target, got.zone);
                return;
            end
            want = due_reports.pop_front();
            if (got.brightness !== want.brightness || got.target !== want.target ||
                got.zone !== want.zone || got.changed !== want.changed ||
                got.row_valid !== want.row_valid) begin
                wrong_count++;
                if (wrong_count <= SHOWN_ERRORS) begin
                    $display("wrong result: expected bright %0d target %0d zone %0d chg %0b valid %0b",
                             want.brightness, want.target, want.zone, want.changed,
                             want.row_valid);
                    $display("              actual   bright %0d target %0d zone %0d chg %0b valid %0b",
                             got.brightness, got.target, got.zone, got.changed, got.row_valid);
                end
            end
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB-style configuration port. pready is tied high inside the block, but
    // the write task still waits on it as the handshake demands.
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    alb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    alb_out_if                             report_ch ();

    ambient_light_backlight_ramp #(
        .NUM_POINTS (NUM_POINTS),
        .MENU_LEVELS(MENU_LEVELS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (sample_ch),
        .o_out  (report_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    backlight_scoreboard backlight_sb;

    // Knobs for the stimulus and the result receiver. The stimulus process
    // sets them, the stall knobs at phase boundaries; the receiver reads those
    // whenever it draws the stall for its next transaction.
    int          tx_gap_max;
    int          rx_stall_max;
    int          rx_long_hold;
    logic [63:0] thr_now;

    // Register write: a setup cycle with penable low, then the access cycle.
    // The scoreboard copy is updated at the edge where the block takes it.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        backlight_sb.write_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one sample transaction after an idle gap of the given length.
    // With no gap, valid simply stays high and the payload moves on, so valid
    // is never dropped and raised within the same time step.
    task automatic send_sample(input logic command, input logic [SAMPLE_BITS-1:0] sample,
                               input logic [LEVEL_W-1:0] new_level, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sample_ch.valid          <= 1'b1;
        sample_ch.command        <= command;
        sample_ch.sample         <= sample;
        sample_ch.new_menu_level <= new_level;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        backlight_sb.note_sample(command, sample, new_level);
    endtask

    // Stops offering samples and waits until every predicted result has been
    // taken, then lets the two-stage pipeline run empty before going on.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        while (backlight_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Samples are drawn from three pools: the range ends, values at or next to
    // the thresholds (where the strict compare matters), and anything else.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int pick;
        int idx;
        int near;
        pick = $urandom_range(0, 99);
        if (pick < 15) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        if (pick < 50) begin
            idx  = $urandom_range(0, NUM_POINTS - 1);
            near = int'(thr_now[THR_BITS*idx +: THR_BITS]) + int'($urandom_range(0, 2)) - 1;
            if (near < 0) near = 0;
            if (near > 4095) near = 4095;
            return SAMPLE_BITS'(near);
        end
        return SAMPLE_BITS'($urandom_range(0, 4095));
    endfunction

    // Writes a full register set for one random phase. The first phases pin
    // the extremes: all-zero and all-one thresholds, full and empty tables,
    // an all-valid and an all-invalid level mask, too many and one active threshold.
    // Later phases mostly use sorted thresholds in or just above the sample range, so
    // that every zone is reached, with the odd fully random word as noise.
    task automatic configure_phase(input int p);
        logic [15:0]       t [NUM_POINTS];
        logic [15:0]       swap;
        logic [DATA_W-1:0] rows [NUM_WORDS];
        logic [DATA_W-1:0] thr;
        logic [2:0]        act;
        logic [MASK_W-1:0] mask;
        int                kind;
        foreach (rows[i]) rows[i] = {$urandom, $urandom};
        foreach (t[i]) t[i] = 16'($urandom_range(0, 4400));
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
            for (int j = 0; j < NUM_POINTS - 1 - i; j++) begin
                if (t[j] > t[j+1]) begin
                    swap   = t[j];
                    t[j]   = t[j+1];
                    t[j+1] = swap;
                end
            end
        end
        thr = {t[3], t[2], t[1], t[0]};
        if ($urandom_range(0, 4) == 0) thr = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        act  = (kind > 7) ? 3'd4 : 3'(kind);
        mask = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom)
                                           : ~(8'd1 << $urandom_range(0, 7));
        case (p)
            0: begin
                thr  = '0;
                act  = 3'd7;
                foreach (rows[i]) rows[i] = '1;
                mask = 8'hFF;
            end
            1: begin
                thr  = '1;
                act  = 3'd4;
                foreach (rows[i]) rows[i] = '0;
                mask = 8'hFF;
            end
            2: begin
                act  = 3'd3;
                mask = 8'h00;
            end
            3: act = 3'd1;
            default: ;
        endcase
        thr_now = thr;
        apb_write(REG_THRESHOLDS, thr);
        apb_write(REG_ACTIVE, {61'($urandom), act});
        apb_write(REG_TABLE_01, rows[0]);
        apb_write(REG_TABLE_23, rows[1]);
        apb_write(REG_TABLE_45, rows[2]);
        apb_write(REG_TABLE_67, rows[3]);
        apb_write(REG_VALID_MASK, {56'($urandom), mask});
    endtask

    // Result receiver. Before each result transaction it lowers ready for a
    // drawn number of cycles, or for one long hold when the stimulus asks for
    // back-pressure. Results are sampled at the rising edge where valid and
    // ready are both high.
    initial begin : result_sink
        int      stall;
        t_result got;
        report_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_long_hold > 0) begin
                stall        = rx_long_hold;
                rx_long_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                report_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            report_ch.ready <= 1'b1;
            do @(posedge i_clk); while (report_ch.valid !== 1'b1);
            got.brightness = report_ch.brightness;
            got.target     = report_ch.target;
            got.zone       = report_ch.zone;
            got.changed    = report_ch.changed;
            got.row_valid  = report_ch.row_valid;
            backlight_sb.check_result(got);
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] row01;
        logic              cmd;
        logic              pressure;
        int                waited;

        // Every input is known from time zero.
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.command        = CMD_TICK;
        sample_ch.sample         = '0;
        sample_ch.new_menu_level = '0;
        tx_gap_max               = MAX_GAP;
        rx_stall_max             = MAX_GAP;
        rx_long_hold             = 0;
        thr_now                  = '1;
        backlight_sb             = new();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset register values every threshold is all
        // ones and no level row is valid: zone 0, target 0, no change, and a
        // level change is stored even though its row is invalid.
        send_sample(CMD_TICK, 12'h000, 3'd0, 0);
        send_sample(CMD_TICK, 12'hFFF, 3'd7, 0);
        send_sample(CMD_LEVEL, 12'h800, 3'd3, 2);
        settle();

        // Thresholds at 100, 1000, 3000 and 4095; level 0 gets target 63 in
        // zone 0 and 0 in zone 4 so that both ramp directions are certain.
        // Level 7 is the one invalid row.
        row01         = {$urandom, $urandom};
        row01[5:0]    = 6'd63;
        row01[29:24]  = 6'd0;
        thr_now       = {16'd4095, 16'd3000, 16'd1000, 16'd100};
        apb_write(REG_THRESHOLDS, thr_now);
        apb_write(REG_ACTIVE, 64'd4);
        apb_write(REG_TABLE_01, row01);
        apb_write(REG_TABLE_23, {$urandom, $urandom});
        apb_write(REG_TABLE_45, {$urandom, $urandom});
        apb_write(REG_TABLE_67, {$urandom, $urandom});
        apb_write(REG_VALID_MASK, 64'h7F);

        send_sample(CMD_LEVEL, 12'd0, 3'd0, 0);     // jump straight to 63
        send_sample(CMD_LEVEL, 12'd50, 3'd0, 1);    // same target on a level change
        send_sample(CMD_TICK, 12'd0, 3'd6, 0);      // same target on a tick
        send_sample(CMD_TICK, 12'd4095, 3'd5, 0);   // zone 4, one step down
        send_sample(CMD_TICK, 12'd99, 3'd0, 3);     // just below the first threshold
        send_sample(CMD_TICK, 12'd100, 3'd0, 0);    // exactly on it
        send_sample(CMD_TICK, 12'd999, 3'd0, 0);
        send_sample(CMD_TICK, 12'd1000, 3'd0, 0);
        send_sample(CMD_TICK, 12'd2999, 3'd0, 0);
        send_sample(CMD_TICK, 12'd3000, 3'd0, 0);
        send_sample(CMD_TICK, 12'd4094, 3'd0, 0);
        send_sample(CMD_LEVEL, 12'd500, 3'd7, 0);   // invalid row: brightness holds
        send_sample(CMD_TICK, 12'd500, 3'd2, 0);
        send_sample(CMD_LEVEL, 12'd3500, 3'd6, 0);  // valid row again: jump
        settle();

        // More active points than exist count as all four.
        apb_write(REG_ACTIVE, 64'd7);
        send_sample(CMD_TICK, 12'd4095, 3'd0, 0);
        send_sample(CMD_TICK, 12'd2000, 3'd0, 0);
        settle();

        // No active points: every sample falls in zone 0.
        apb_write(REG_ACTIVE, 64'd0);
        send_sample(CMD_TICK, 12'd4095, 3'd0, 0);
        send_sample(CMD_LEVEL, 12'd0, 3'd2, 0);
        settle();

        // Random part, one register set per phase. Most transactions are ticks
        // so the brightness really ramps between level changes. Some phases run
        // with no gaps on one side or the other; in two of them the receiver
        // holds off for a long stretch while samples keep coming, so the block
        // fills up and must stall its input.
        for (int p = 0; p < NUM_PHASES; p++) begin
            configure_phase(p);
            pressure     = (p == 4 || p == 9);
            tx_gap_max   = (pressure || p % 3 == 0) ? 0 : MAX_GAP;
            rx_stall_max = (p % 4 == 1) ? 0 : MAX_GAP;
            if (pressure) rx_long_hold = LONG_HOLD;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd = ($urandom_range(0, 99) < 15) ? CMD_LEVEL : CMD_TICK;
                send_sample(cmd, pick_sample(), LEVEL_W'($urandom_range(0, 7)),
                            $urandom_range(0, tx_gap_max));
            end
            settle();
        end

        // Any prediction still waiting now never got its result.
        waited = 0;
        while (backlight_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (backlight_sb.wrong_count == 0 && backlight_sb.pending() == 0) begin
            $display("ambient_light_backlight_ramp: match");
        end else begin
            $display("ambient_light_backlight_ramp: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("ambient_light_backlight_ramp: mismatch");
        $finish;
    end

endmodule

// ===== ambient_light_backlight_ramp.f =====
rtl/core/alb_pkg.sv
rtl/core/alb_if.sv
rtl/core/alb_regs.sv
rtl/core/alb_zone.sv
rtl/core/alb_ramp.sv
rtl/core/ambient_light_backlight_ramp.sv
bench/tb_ambient_light_backlight_ramp.sv
